/* sv/tpdo_tt_pkg.sv */
// ----------------------------------------------------------------------------
// tpdo_tt_pkg
// Shared types, codes and helpers of the transmit trigger block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpdo_tt_pkg;

  // channel count limits
  localparam int TT_MAX_CHANNELS = 4;
  localparam int TT_DEF_CHANNELS = 4;

  // field widths
  localparam int TT_TIME_W   = 32;
  localparam int TT_DATA_W   = 64;
  localparam int TT_LEN_W    = 4;
  localparam int TT_ID_W     = 11;
  localparam int TT_PERIOD_W = 16;
  localparam int TT_CH_W     = 2;
  localparam int TT_STAT_W   = 3;
  localparam int TT_ERR_W    = 2;
  localparam int TT_CFG_IX_W = 2;

  // configuration register widths
  localparam int TT_EN_W  = TT_MAX_CHANNELS;
  localparam int TT_IDS_W = TT_MAX_CHANNELS * TT_ID_W;
  localparam int TT_PER_W = TT_MAX_CHANNELS * TT_PERIOD_W;

  // largest legal payload length in bytes
  localparam logic [TT_LEN_W-1:0] TT_MAX_LEN = 4'd8;

  // configuration register indexes
  localparam logic [TT_CFG_IX_W-1:0] CFG_ENABLES     = 2'd0;
  localparam logic [TT_CFG_IX_W-1:0] CFG_IDENTIFIERS = 2'd1;
  localparam logic [TT_CFG_IX_W-1:0] CFG_EVENT       = 2'd2;
  localparam logic [TT_CFG_IX_W-1:0] CFG_INHIBIT     = 2'd3;

  // item functions
  localparam logic FUNC_SERVICE = 1'b0;
  localparam logic FUNC_MARK    = 1'b1;

  // result status codes
  localparam logic [TT_STAT_W-1:0] ST_SENT       = 3'd0;
  localparam logic [TT_STAT_W-1:0] ST_DISABLED   = 3'd1;
  localparam logic [TT_STAT_W-1:0] ST_NOT_DUE    = 3'd2;
  localparam logic [TT_STAT_W-1:0] ST_INHIBITED  = 3'd3;
  localparam logic [TT_STAT_W-1:0] ST_PACK_FAIL  = 3'd4;
  localparam logic [TT_STAT_W-1:0] ST_UNCHANGED  = 3'd5;
  localparam logic [TT_STAT_W-1:0] ST_TX_REFUSED = 3'd6;

  // error codes
  localparam logic [TT_ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [TT_ERR_W-1:0] ERR_PACK    = 2'd1;
  localparam logic [TT_ERR_W-1:0] ERR_TRANSMIT = 2'd2;

  // one input word as held in the input stage
  typedef struct packed {
    logic                 func;
    logic [TT_CH_W-1:0]   channel;
    logic [TT_TIME_W-1:0] now_ms;
    logic [TT_DATA_W-1:0] payload;
    logic [TT_LEN_W-1:0]  payload_length;
    logic                 pack_ok;
    logic                 tx_ready;
  } item_t;

  // one result word
  typedef struct packed {
    logic [TT_STAT_W-1:0] status;
    logic                 send;
    logic [TT_ID_W-1:0]   frame_id;
    logic [TT_LEN_W-1:0]  frame_length;
    logic [TT_DATA_W-1:0] frame_data;
    logic [TT_ERR_W-1:0]  error_code;
  } result_t;

  // keep only the first len bytes
  function automatic logic [TT_DATA_W-1:0] byte_mask(input logic [TT_LEN_W-1:0] len);
    logic [TT_DATA_W-1:0] m;
    for (int k = 0; k < TT_DATA_W / 8; k++) begin
      m[8*k +: 8] = (TT_LEN_W'(k) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* sv/tpdo_tt_if.sv */
// ----------------------------------------------------------------------------
// tpdo_tt_if
// Valid/ready channels of the transmit trigger: input, result and config.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpdo_tt_in_if;
  import tpdo_tt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [TT_CH_W-1:0]   channel;
  logic [TT_TIME_W-1:0] now_ms;
  logic [TT_DATA_W-1:0] payload;
  logic [TT_LEN_W-1:0]  payload_length;
  logic                 pack_ok;
  logic                 tx_ready;

  modport source (output valid, func, channel, now_ms, payload, payload_length,
                  pack_ok, tx_ready, input ready);
  modport sink   (input valid, func, channel, now_ms, payload, payload_length,
                  pack_ok, tx_ready, output ready);
endinterface

interface tpdo_tt_out_if;
  import tpdo_tt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TT_STAT_W-1:0] status;
  logic                 send;
  logic [TT_ID_W-1:0]   frame_id;
  logic [TT_LEN_W-1:0]  frame_length;
  logic [TT_DATA_W-1:0] frame_data;
  logic [TT_ERR_W-1:0]  error_code;

  modport source (output valid, status, send, frame_id, frame_length, frame_data,
                  error_code, input ready);
  modport sink   (input valid, status, send, frame_id, frame_length, frame_data,
                  error_code, output ready);
endinterface

interface tpdo_tt_cfg_if;
  import tpdo_tt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [TT_CFG_IX_W-1:0] index;
  logic [TT_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/tpdo_transmit_trigger_core.sv */
// ----------------------------------------------------------------------------
// tpdo_transmit_trigger_core
// Event timer / inhibit trigger for transmit process-data channels.
// ----------------------------------------------------------------------------
// Flow: an accepted input word is held in the input register; its result word
// is then loaded into the result register. Throughput: one word per cycle while
// rsp.ready holds; input register, one compare/subtract pass over the addressed
// channel's state, result register. Reset: clears config, all channel state and
// both stages; config port is always ready.
`default_nettype none

module tpdo_transmit_trigger_core
  import tpdo_tt_pkg::*;
#(
  parameter int CHANNELS = TT_DEF_CHANNELS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tpdo_tt_in_if.sink    req,
  tpdo_tt_out_if.source rsp,
  tpdo_tt_cfg_if.sink   cfg
);

  localparam int IX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [TT_CH_W:0] CH_LIMIT = (TT_CH_W + 1)'(CHANNELS);

  // configuration registers
  logic [TT_EN_W-1:0]  channel_enables;
  logic [TT_IDS_W-1:0] channel_identifiers;
  logic [TT_PER_W-1:0] event_periods;
  logic [TT_PER_W-1:0] inhibit_periods;

  // per-channel state
  logic [TT_TIME_W-1:0] last_send_time     [CHANNELS];
  logic [TT_LEN_W-1:0]  last_length        [CHANNELS];
  logic [TT_DATA_W-1:0] last_payload_bytes [CHANNELS];
  logic                 has_sent           [CHANNELS];
  logic                 pending            [CHANNELS];

  // pipeline stages
  logic    s1_valid;
  item_t   s1;
  logic    out_valid;
  result_t res;
  result_t res_next;

  logic s2_load;
  logic fire;

  // handshake
  assign s2_load   = !out_valid || rsp.ready;
  assign fire      = s1_valid && s2_load;
  assign req.ready = !s1_valid || s2_load;
  assign cfg.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enables     <= '0;
      channel_identifiers <= '0;
      event_periods       <= '0;
      inhibit_periods     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ENABLES:     channel_enables     <= cfg.data[TT_EN_W-1:0];
        CFG_IDENTIFIERS: channel_identifiers <= cfg.data[TT_IDS_W-1:0];
        CFG_EVENT:       event_periods       <= cfg.data[TT_PER_W-1:0];
        CFG_INHIBIT:     inhibit_periods     <= cfg.data[TT_PER_W-1:0];
        default:         ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1.func           <= req.func;
      s1.channel        <= req.channel;
      s1.now_ms         <= req.now_ms;
      s1.payload        <= req.payload;
      s1.payload_length <= req.payload_length;
      s1.pack_ok        <= req.pack_ok;
      s1.tx_ready       <= req.tx_ready;
    end
  end

  // decision logic for the word in the input stage
  logic [IX_W-1:0]         idx;
  logic                    in_range;
  logic                    ch_enabled;
  logic [TT_TIME_W-1:0]    elapsed;
  logic [TT_PERIOD_W-1:0]  ev;
  logic [TT_PERIOD_W-1:0]  inh;
  logic                    due;
  logic                    inhibited;
  logic                    pack_bad;
  logic [TT_DATA_W-1:0]    data;
  logic                    unchanged;
  logic [TT_ID_W-1:0]      ident;
  logic                    do_send;
  logic                    clear_pending;
  logic                    set_pending;

  assign idx        = s1.channel[IX_W-1:0];
  assign in_range   = {1'b0, s1.channel} < CH_LIMIT;
  assign ch_enabled = in_range && channel_enables[s1.channel];
  assign elapsed    = s1.now_ms - last_send_time[idx];
  assign ev         = event_periods[TT_PERIOD_W*s1.channel +: TT_PERIOD_W];
  assign inh        = inhibit_periods[TT_PERIOD_W*s1.channel +: TT_PERIOD_W];
  assign ident      = channel_identifiers[TT_ID_W*s1.channel +: TT_ID_W];
  assign due        = pending[idx] ||
                      ((ev != '0) && (elapsed >= {{(TT_TIME_W-TT_PERIOD_W){1'b0}}, ev}));
  assign inhibited  = (inh != '0) &&
                      (elapsed < {{(TT_TIME_W-TT_PERIOD_W){1'b0}}, inh});
  assign pack_bad   = !s1.pack_ok || (s1.payload_length > TT_MAX_LEN);
  assign data       = s1.payload & byte_mask(s1.payload_length);
  assign unchanged  = has_sent[idx] && (last_length[idx] == s1.payload_length) &&
                      (last_payload_bytes[idx] == data);

  always_comb begin
    res_next      = '0;
    do_send       = 1'b0;
    clear_pending = 1'b0;
    set_pending   = 1'b0;
    priority if (s1.func == FUNC_MARK) begin
      res_next.status = ST_NOT_DUE;
      set_pending     = in_range;
    end else if (!ch_enabled) begin
      res_next.status = ST_DISABLED;
    end else if (!due) begin
      res_next.status = ST_NOT_DUE;
    end else if (inhibited) begin
      res_next.status = ST_INHIBITED;
    end else if (pack_bad) begin
      res_next.status     = ST_PACK_FAIL;
      res_next.error_code = ERR_PACK;
    end else if (unchanged) begin
      res_next.status = ST_UNCHANGED;
      clear_pending   = 1'b1;
    end else if (!s1.tx_ready) begin
      res_next.status     = ST_TX_REFUSED;
      res_next.error_code = ERR_TRANSMIT;
    end else begin
      res_next.status       = ST_SENT;
      res_next.send         = 1'b1;
      res_next.frame_id     = ident;
      res_next.frame_length = s1.payload_length;
      res_next.frame_data   = data;
      do_send               = 1'b1;
      clear_pending         = 1'b1;
    end
  end

  // channel state update, at the edge the word leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_send_time[i]     <= '0;
        last_length[i]        <= '0;
        last_payload_bytes[i] <= '0;
        has_sent[i]           <= 1'b0;
        pending[i]            <= 1'b0;
      end
    end else if (fire) begin
      if (set_pending) begin
        pending[idx] <= 1'b1;
      end else if (clear_pending) begin
        pending[idx] <= 1'b0;
      end
      if (do_send) begin
        last_send_time[idx]     <= s1.now_ms;
        last_length[idx]        <= s1.payload_length;
        last_payload_bytes[idx] <= data;
        has_sent[idx]           <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = res.status;
  assign rsp.send         = res.send;
  assign rsp.frame_id     = res.frame_id;
  assign rsp.frame_length = res.frame_length;
  assign rsp.frame_data   = res.frame_data;
  assign rsp.error_code   = res.error_code;

  // checks
  a_send_is_sent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.send == (res.status == ST_SENT)))
    else $error("send flag disagrees with status");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (s1_valid && out_valid && !rsp.ready))
    else $error("input stalled without a blocked result");

  a_send_records: assert property (@(posedge clk) disable iff (rst)
    (fire && do_send) |=> (has_sent[$past(idx)] && !pending[$past(idx)]))
    else $error("send did not record channel state");

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the transmit trigger core. A short directed table
// covers reset, the status and error codes, the byte compare and the time
// wrap. Random traffic under several register settings follows. Every result
// word is checked against its typed row or a predictor run on accepted words.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tpdo_tt_pkg::*;

  localparam int NUM_CH         = TT_DEF_CHANNELS;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETUP_ROWS     = 2;
  localparam int PHASES         = 6;

  typedef struct packed {
    item_t   w;
    logic    typed;
    result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  tpdo_tt_in_if  req_ch ();
  tpdo_tt_out_if rsp_ch ();
  tpdo_tt_cfg_if cfg_ch ();

  tpdo_transmit_trigger_core #(.CHANNELS(NUM_CH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // register copies
  logic [TT_EN_W-1:0]  en_reg  = '0;
  logic [TT_IDS_W-1:0] id_reg  = '0;
  logic [TT_PER_W-1:0] ev_reg  = '0;
  logic [TT_PER_W-1:0] inh_reg = '0;

  // per-channel send history and pending marks
  logic [TT_TIME_W-1:0] sent_at    [NUM_CH];
  logic [TT_LEN_W-1:0]  sent_len   [NUM_CH];
  logic [TT_DATA_W-1:0] sent_bytes [NUM_CH];
  logic                 sent_ok    [NUM_CH];
  logic                 marked     [NUM_CH];

  result_t   decisions_q [$];
  plan_row_t plan_q [$];
  result_t   head;

  int   faults      = 0;
  int   idle_cycles = 0;
  logic steady      = 1'b0;
  logic rx_hold     = 1'b0;
  logic [TT_TIME_W-1:0] clock_ms;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // first n bytes kept
  function automatic logic [TT_DATA_W-1:0] low_bytes(input logic [TT_LEN_W-1:0] n);
    if (n >= TT_MAX_LEN) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // trigger decision for one word, history updated as the block would
  function automatic result_t decide_trigger(input item_t w);
    result_t              r;
    logic [TT_TIME_W-1:0] gap_ms;
    logic [15:0]          ev;
    logic [15:0]          inh;
    logic [TT_DATA_W-1:0] bytes;
    logic                 fire;
    r = '0;
    r.status = ST_NOT_DUE;
    r.error_code = ERR_NONE;
    if (w.func == FUNC_MARK) begin
      if (int'(w.channel) < NUM_CH) marked[w.channel] = 1'b1;
      return r;
    end
    if (int'(w.channel) >= NUM_CH || !en_reg[w.channel]) begin
      r.status = ST_DISABLED;
      return r;
    end
    gap_ms = w.now_ms - sent_at[w.channel];
    ev     = ev_reg[w.channel * TT_PERIOD_W +: TT_PERIOD_W];
    inh    = inh_reg[w.channel * TT_PERIOD_W +: TT_PERIOD_W];
    fire   = marked[w.channel] || (ev != 16'd0 && gap_ms >= {16'd0, ev});
    if (!fire) return r;
    if (inh != 16'd0 && gap_ms < {16'd0, inh}) begin
      r.status = ST_INHIBITED;
      return r;
    end
    if (!w.pack_ok || w.payload_length > TT_MAX_LEN) begin
      r.status = ST_PACK_FAIL;
      r.error_code = ERR_PACK;
      return r;
    end
    bytes = w.payload & low_bytes(w.payload_length);
    // same bytes as the last frame: drop it and clear the mark
    if (sent_ok[w.channel] && sent_len[w.channel] == w.payload_length &&
        sent_bytes[w.channel] == bytes) begin
      marked[w.channel] = 1'b0;
      r.status = ST_UNCHANGED;
      return r;
    end
    if (!w.tx_ready) begin
      r.status = ST_TX_REFUSED;
      r.error_code = ERR_TRANSMIT;
      return r;
    end
    sent_at[w.channel]    = w.now_ms;
    sent_len[w.channel]   = w.payload_length;
    sent_bytes[w.channel] = bytes;
    sent_ok[w.channel]    = 1'b1;
    marked[w.channel]     = 1'b0;
    r.status       = ST_SENT;
    r.send         = 1'b1;
    r.frame_id     = id_reg[w.channel * TT_ID_W +: TT_ID_W];
    r.frame_length = w.payload_length;
    r.frame_data   = bytes;
    return r;
  endfunction

  function automatic item_t mk_item(input logic f, input logic [TT_CH_W-1:0] ch,
                                    input logic [TT_TIME_W-1:0] now,
                                    input logic [TT_DATA_W-1:0] pay,
                                    input logic [TT_LEN_W-1:0] len,
                                    input logic pk, input logic tx);
    item_t w;
    w.func = f;
    w.channel = ch;
    w.now_ms = now;
    w.payload = pay;
    w.payload_length = len;
    w.pack_ok = pk;
    w.tx_ready = tx;
    return w;
  endfunction

  function automatic result_t mk_result(input logic [TT_STAT_W-1:0] st, input logic snd,
                                        input logic [TT_ID_W-1:0] id,
                                        input logic [TT_LEN_W-1:0] len,
                                        input logic [TT_DATA_W-1:0] data,
                                        input logic [TT_ERR_W-1:0] err);
    result_t r;
    r.status = st;
    r.send = snd;
    r.frame_id = id;
    r.frame_length = len;
    r.frame_data = data;
    r.error_code = err;
    return r;
  endfunction

  function automatic void plan(input item_t w, input logic typed, input result_t want);
    plan_row_t row;
    row.w = w;
    row.typed = typed;
    row.want = want;
    plan_q.push_back(row);
  endfunction

  // four 16-bit periods, some off, most short, a few anywhere
  function automatic logic [TT_PER_W-1:0] lanes(input int hi);
    logic [TT_PER_W-1:0] v;
    int r;
    for (int k = 0; k < NUM_CH; k++) begin
      r = $urandom_range(0, 99);
      if (r < 25) v[16*k +: 16] = 16'd0;
      else if (r < 85) v[16*k +: 16] = 16'($urandom_range(1, hi));
      else v[16*k +: 16] = 16'($urandom);
    end
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one input word; valid stays high into the next word unless a gap follows
  task automatic offer(input item_t w, input logic typed, input result_t want);
    result_t guess;
    int gap;
    req_ch.valid          <= 1'b1;
    req_ch.func           <= w.func;
    req_ch.channel        <= w.channel;
    req_ch.now_ms         <= w.now_ms;
    req_ch.payload        <= w.payload;
    req_ch.payload_length <= w.payload_length;
    req_ch.pack_ok        <= w.pack_ok;
    req_ch.tx_ready       <= w.tx_ready;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    guess = decide_trigger(w);
    decisions_q.push_back(typed ? want : guess);
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (decisions_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(input logic [TT_CFG_IX_W-1:0] ix, input logic [TT_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ix;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (ix)
      CFG_ENABLES:     en_reg  = val[TT_EN_W-1:0];
      CFG_IDENTIFIERS: id_reg  = val[TT_IDS_W-1:0];
      CFG_EVENT:       ev_reg  = val;
      CFG_INHIBIT:     inh_reg = val;
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [TT_EN_W-1:0] en, input logic [TT_IDS_W-1:0] ids,
                            input logic [TT_PER_W-1:0] ev, input logic [TT_PER_W-1:0] inh);
    put_reg(CFG_ENABLES, 64'(en));
    put_reg(CFG_IDENTIFIERS, 64'(ids));
    put_reg(CFG_EVENT, ev);
    put_reg(CFG_INHIBIT, inh);
    cfg_ch.valid <= 1'b0;
  endtask

  // result sink with random stalls and one long hold-off on request
  initial begin
    int stall;
    int r;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (rx_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else if (steady) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          rsp_ch.ready <= 1'b1;
        end else if (r < 95) begin
          rsp_ch.ready <= 1'b0;
          stall = $urandom_range(0, 2);
        end else begin
          rsp_ch.ready <= 1'b0;
          stall = $urandom_range(9, 39);
        end
      end
    end
  end

  // compare each result word with the oldest decision
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (decisions_q.size() == 0) begin
        $error("result word with nothing outstanding: status %0d", rsp_ch.status);
        faults++;
      end else begin
        head = decisions_q.pop_front();
        if (rsp_ch.status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, rsp_ch.status);
          faults++;
        end
        if (rsp_ch.send !== head.send) begin
          $error("send: expected %0d, got %0d", head.send, rsp_ch.send);
          faults++;
        end
        if (rsp_ch.frame_id !== head.frame_id) begin
          $error("frame_id: expected %h, got %h", head.frame_id, rsp_ch.frame_id);
          faults++;
        end
        if (rsp_ch.frame_length !== head.frame_length) begin
          $error("frame_length: expected %0d, got %0d", head.frame_length,
                 rsp_ch.frame_length);
          faults++;
        end
        if (rsp_ch.frame_data !== head.frame_data) begin
          $error("frame_data: expected %h, got %h", head.frame_data, rsp_ch.frame_data);
          faults++;
        end
        if (rsp_ch.error_code !== head.error_code) begin
          $error("error_code: expected %0d, got %0d", head.error_code, rsp_ch.error_code);
          faults++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    item_t                w;
    logic [TT_CH_W-1:0]   ch;
    logic [TT_LEN_W-1:0]  len;
    logic [TT_DATA_W-1:0] pay;
    logic                 fn;
    int                   n;
    int                   count;
    int                   r;
    int                   step;

    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.func           <= FUNC_SERVICE;
    req_ch.channel        <= '0;
    req_ch.now_ms         <= '0;
    req_ch.payload        <= '0;
    req_ch.payload_length <= '0;
    req_ch.pack_ok        <= 1'b0;
    req_ch.tx_ready       <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_ENABLES;
    cfg_ch.data           <= '0;
    for (int k = 0; k < NUM_CH; k++) begin
      sent_at[k]    = '0;
      sent_len[k]   = '0;
      sent_bytes[k] = '0;
      sent_ok[k]    = 1'b0;
      marked[k]     = 1'b0;
    end

    // directed table; rows before the setup run with reset registers
    plan(mk_item(FUNC_SERVICE, 2'd2, 32'd0, 64'd0, 4'd0, 1'b1, 1'b1), 1'b1,
         mk_result(ST_DISABLED, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_MARK, 2'd3, 32'd0, 64'd0, 4'd0, 1'b1, 1'b1), 1'b1,
         mk_result(ST_NOT_DUE, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_SERVICE, 2'd3, 32'd1, '1, 4'd8, 1'b1, 1'b1), 1'b1,
         mk_result(ST_DISABLED, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd5, '1, 4'd8, 1'b1, 1'b1), 1'b1,
         mk_result(ST_NOT_DUE, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_MARK, 2'd0, 32'd5, 64'd0, 4'd0, 1'b0, 1'b0), 1'b1,
         mk_result(ST_NOT_DUE, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd5, '1, 4'd8, 1'b1, 1'b1), 1'b1,
         mk_result(ST_SENT, 1'b1, 11'h7FF, 4'd8, '1, ERR_NONE));
    plan(mk_item(FUNC_MARK, 2'd0, 32'd6, 64'd0, 4'd0, 1'b1, 1'b1), 1'b1,
         mk_result(ST_NOT_DUE, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd6, '1, 4'd8, 1'b1, 1'b1), 1'b1,
         mk_result(ST_UNCHANGED, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd7, 64'd0, 4'd1, 1'b1, 1'b1), 1'b1,
         mk_result(ST_NOT_DUE, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_MARK, 2'd0, 32'd7, 64'd0, 4'd0, 1'b1, 1'b1), 1'b1,
         mk_result(ST_NOT_DUE, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd8, 64'd0, 4'd8, 1'b0, 1'b1), 1'b1,
         mk_result(ST_PACK_FAIL, 1'b0, '0, '0, '0, ERR_PACK));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd9, 64'd0, 4'd9, 1'b1, 1'b1), 1'b1,
         mk_result(ST_PACK_FAIL, 1'b0, '0, '0, '0, ERR_PACK));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd10, 64'd0, 4'd15, 1'b1, 1'b1), 1'b1,
         mk_result(ST_PACK_FAIL, 1'b0, '0, '0, '0, ERR_PACK));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd11, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, 1'b0),
         1'b1, mk_result(ST_TX_REFUSED, 1'b0, '0, '0, '0, ERR_TRANSMIT));
    plan(mk_item(FUNC_SERVICE, 2'd0, 32'd12, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, 1'b1),
         1'b1, mk_result(ST_SENT, 1'b1, 11'h7FF, 4'd0, '0, ERR_NONE));
    // event timer one short of its period
    plan(mk_item(FUNC_SERVICE, 2'd1, 32'h0000_FFFE, '1, 4'd3, 1'b1, 1'b1), 1'b1,
         mk_result(ST_NOT_DUE, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_SERVICE, 2'd1, 32'h0000_FFFF, 64'h0123_4567_89AB_CDEF, 4'd3, 1'b1,
                 1'b1), 1'b0, '0);
    // only the first length bytes take part in the compare
    plan(mk_item(FUNC_MARK, 2'd1, 32'h0001_0000, 64'd0, 4'd0, 1'b1, 1'b1), 1'b0, '0);
    plan(mk_item(FUNC_SERVICE, 2'd1, 32'h0001_0000, 64'hFFFF_FFFF_FFAB_CDEF, 4'd3, 1'b1,
                 1'b1), 1'b0, '0);
    // time wrap through zero with inhibit and event timer
    plan(mk_item(FUNC_SERVICE, 2'd2, 32'hFFFF_FFF0, 64'h55AA, 4'd2, 1'b1, 1'b1), 1'b0, '0);
    plan(mk_item(FUNC_MARK, 2'd2, 32'hFFFF_FFF0, '1, 4'd15, 1'b0, 1'b0), 1'b1,
         mk_result(ST_NOT_DUE, 1'b0, '0, '0, '0, ERR_NONE));
    plan(mk_item(FUNC_SERVICE, 2'd2, 32'h0000_0010, 64'hAA55, 4'd2, 1'b1, 1'b1), 1'b0, '0);
    plan(mk_item(FUNC_SERVICE, 2'd2, 32'h0000_0060, 64'hAA55, 4'd2, 1'b1, 1'b1), 1'b0, '0);
    plan(mk_item(FUNC_SERVICE, 2'd2, 32'h0000_00C4, 64'hAA55, 4'd2, 1'b1, 1'b1), 1'b0, '0);
    plan(mk_item(FUNC_SERVICE, 2'd1, 32'hFFFF_FFFF, 64'd0, 4'd8, 1'b1, 1'b0), 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    n = 0;
    foreach (plan_q[i]) begin
      if (n == SETUP_ROWS) begin
        settle();
        // channel 3 off; ids at both ends; timers on channels 1 and 2
        write_regs(4'b0111, {11'h555, 11'h123, 11'h000, 11'h7FF},
                   {16'h0000, 16'd100, 16'hFFFF, 16'h0000},
                   {16'h0000, 16'd50, 16'h0000, 16'h0000});
      end
      offer(plan_q[i].w, plan_q[i].typed, plan_q[i].want);
      n++;
    end

    // random traffic, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      settle();
      steady = (p == 3);
      case (p)
        0: write_regs(4'hF, TT_IDS_W'({$urandom, $urandom}), lanes(60), lanes(30));
        1: write_regs('1, '1, '1, '1);
        2: write_regs('0, '0, '0, '0);
        3: write_regs(TT_EN_W'($urandom), TT_IDS_W'({$urandom, $urandom}), lanes(60),
                      lanes(30));
        4: write_regs(4'hF, '0, lanes(40), '0);
        default: write_regs(TT_EN_W'($urandom), TT_IDS_W'({$urandom, $urandom}),
                            {$urandom, $urandom}, lanes(30));
      endcase
      clock_ms = (p % 2 == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3000);
      count = (p == 2) ? 60 : 360;
      for (int i = 0; i < count; i++) begin
        // long sink hold-off while words keep coming, later a full drain
        if (p == 0 && i == 100) rx_hold = 1'b1;
        if (p == 0 && i == 250) settle();
        r = $urandom_range(0, 99);
        if (r < 60) step = $urandom_range(0, 3);
        else if (r < 90) step = $urandom_range(4, 80);
        else if (r < 98) step = $urandom_range(81, 2000);
        else step = $urandom_range(60000, 140000);
        clock_ms = clock_ms + step;
        ch = TT_CH_W'($urandom_range(0, NUM_CH - 1));
        fn = ($urandom_range(0, 99) < 20) ? FUNC_MARK : FUNC_SERVICE;
        if (fn == FUNC_SERVICE && sent_ok[ch] && $urandom_range(0, 99) < 45) begin
          // last frame's bytes again, junk above the length
          len = sent_len[ch];
          pay = sent_bytes[ch] | ({$urandom, $urandom} & ~low_bytes(len));
        end else begin
          pay = {$urandom, $urandom};
          len = ($urandom_range(0, 9) < 9) ? TT_LEN_W'($urandom_range(0, 8))
                                           : TT_LEN_W'($urandom_range(9, 15));
        end
        w = mk_item(fn, ch, clock_ms, pay, len, $urandom_range(0, 99) < 92,
                    $urandom_range(0, 99) < 85);
        offer(w, 1'b0, '0);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (faults == 0 && decisions_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
